FILE: src/audio_frame_ring_drop_oldest_macros.svh
// assertion macros for the audio frame ring
`ifndef AUDIO_FRAME_RING_DROP_OLDEST_MACROS_SVH
`define AUDIO_FRAME_RING_DROP_OLDEST_MACROS_SVH
`ifndef SYNTH
`define AFRDO_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("afrdo check failed");
`define AFRDO_IMPLIES(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("afrdo check failed");
`define AFRDO_IMPLIES_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("afrdo check failed");
`else
`define AFRDO_ASSERT(label, expr)
`define AFRDO_IMPLIES(label, lhs, rhs)
`define AFRDO_IMPLIES_NEXT(label, lhs, rhs)
`endif
`endif

FILE: src/afrdo_pkg.sv
// shared types and constants of the audio frame ring
`timescale 1ns / 1ps
package afrdo_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int FRAME_SAMPLES_DEF = 32;
    localparam int OPC_W             = 2;
    localparam int SAMPLE_W          = 16;
    localparam int FRAMES_W          = 5;
    localparam int TOTAL_W           = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic                run;
        logic                ok;
        logic [FRAMES_W-1:0] frames;
        logic [TOTAL_W-1:0]  underflow;
        logic [TOTAL_W-1:0]  overflow;
    } job_t;

    localparam int JOB_W = $bits(job_t);

endpackage

FILE: src/afrdo_if.sv
// request and result channel interfaces of the audio frame ring
`timescale 1ns / 1ps
interface afrdo_in_if import afrdo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPC_W-1:0]           opcode;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output opcode, output sample_in, input ready);
    modport sink (input valid, input opcode, input sample_in, output ready);
endinterface

interface afrdo_out_if import afrdo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last;
    logic                       ok;
    logic [FRAMES_W-1:0]        frames_held;
    logic [TOTAL_W-1:0]         underflow_total;
    logic [TOTAL_W-1:0]         overflow_total;

    modport source (output valid, output sample_out, output last, output ok,
                    output frames_held, output underflow_total, output overflow_total,
                    input ready);
    modport sink (input valid, input sample_out, input last, input ok,
                  input frames_held, input underflow_total, input overflow_total,
                  output ready);
endinterface

FILE: src/afrdo_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module afrdo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/afrdo_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
module afrdo_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam logic [1:0] FILL_FULL = 2'd2;

    logic [WIDTH-1:0] slot_reg [2];
    logic [0:0]       wptr_reg;
    logic [0:0]       rptr_reg;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             wr;
    logic             rd;

    assign wr_ready = (fill_reg != FILL_FULL);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_comb
    begin
        fill_next = fill_reg;
        if (wr && !rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/afrdo_front.sv
// front: takes requests, keeps ring pointers and counters, writes samples
`timescale 1ns / 1ps
module afrdo_front import afrdo_pkg::*; #(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF,
    parameter int STORE_WORDS   = CAPACITY * FRAME_SAMPLES,
    parameter int AW            = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    afrdo_in_if.sink            in_ch,
    input  logic                run_done,
    input  logic                q_ready,
    output logic                q_valid,
    output job_t                q_job,
    output logic [AW-1:0]       q_base,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [SAMPLE_W-1:0] mem_wdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   wpos_reg, wpos_next;
    logic [AW-1:0]      waddr_reg, waddr_next;
    logic [AW-1:0]      rbase_reg, rbase_next;
    logic [TOTAL_W-1:0] ufl_reg, ufl_next;
    logic [TOTAL_W-1:0] ovf_reg, ovf_next;
    logic               run_out_reg, run_out_next;
    logic               accept;
    logic [AW-1:0]      rbase_step;
    logic [CNT_W+FRAMES_W-1:0] cnt_ext;

    assign in_ch.ready = q_ready && !run_out_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign rbase_step  = (rbase_reg == AW'(STORE_WORDS - FRAME_SAMPLES)) ? '0
                                                                          : rbase_reg + AW'(FRAME_SAMPLES);

    assign mem_waddr = waddr_reg;
    assign mem_wdata = in_ch.sample_in;
    assign q_valid   = accept;
    assign q_base    = rbase_reg;

    always_comb
    begin
        logic [CNT_W-1:0] cnt_mid;
        cnt_mid      = count_reg;
        count_next   = count_reg;
        wpos_next    = wpos_reg;
        waddr_next   = waddr_reg;
        rbase_next   = rbase_reg;
        ufl_next     = ufl_reg;
        ovf_next     = ovf_reg;
        run_out_next = run_out_reg;
        mem_we       = 1'b0;
        q_job.run    = 1'b0;
        q_job.ok     = 1'b1;
        if (run_done)
        begin
            run_out_next = 1'b0;
        end
        if (accept)
        begin
            case (in_ch.opcode)
                OP_PUSH:
                begin
                    // a new frame on a full ring drops the oldest one
                    if (wpos_reg == '0 && count_reg == CNT_W'(CAPACITY))
                    begin
                        rbase_next = rbase_step;
                        cnt_mid    = CNT_W'(CAPACITY - 1);
                        ovf_next   = ovf_reg + TOTAL_W'(1);
                    end
                    mem_we     = 1'b1;
                    waddr_next = (waddr_reg == AW'(STORE_WORDS - 1)) ? '0
                                                                     : waddr_reg + AW'(1);
                    if (wpos_reg == POS_W'(FRAME_SAMPLES - 1))
                    begin
                        wpos_next  = '0;
                        count_next = cnt_mid + CNT_W'(1);
                    end
                    else
                    begin
                        wpos_next  = wpos_reg + POS_W'(1);
                        count_next = cnt_mid;
                    end
                end
                OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        ufl_next = ufl_reg + TOTAL_W'(1);
                        q_job.ok = 1'b0;
                    end
                    else
                    begin
                        q_job.run    = 1'b1;
                        rbase_next   = rbase_step;
                        count_next   = count_reg - CNT_W'(1);
                        run_out_next = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    wpos_next  = '0;
                    waddr_next = '0;
                    rbase_next = '0;
                end
                default:
                begin
                    q_job.ok = 1'b0;
                end
            endcase
        end
        cnt_ext         = {{FRAMES_W{1'b0}}, count_next};
        q_job.frames    = cnt_ext[FRAMES_W-1:0];
        q_job.underflow = ufl_next;
        q_job.overflow  = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            wpos_reg    <= '0;
            waddr_reg   <= '0;
            rbase_reg   <= '0;
            ufl_reg     <= '0;
            ovf_reg     <= '0;
            run_out_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            wpos_reg    <= wpos_next;
            waddr_reg   <= waddr_next;
            rbase_reg   <= rbase_next;
            ufl_reg     <= ufl_next;
            ovf_reg     <= ovf_next;
            run_out_reg <= run_out_next;
        end
    end

endmodule

FILE: src/afrdo_back.sv
// back: turns jobs into results, reads popped frames out of the ram
`timescale 1ns / 1ps
`include "audio_frame_ring_drop_oldest_macros.svh"
module afrdo_back import afrdo_pkg::*; #(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF,
    parameter int STORE_WORDS   = CAPACITY * FRAME_SAMPLES,
    parameter int AW            = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  job_t                q_job,
    input  logic [AW-1:0]       q_base,
    output logic                run_done,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [SAMPLE_W-1:0] mem_rdata,
    afrdo_out_if.source         out_ch
);

    localparam int POS_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

    back_state_t         state_reg, state_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    idx_reg;
    logic [AW-1:0]       base_reg;
    job_t                job_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;
    logic                ok_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [TOTAL_W-1:0]  ufl_reg;
    logic [TOTAL_W-1:0]  ovf_reg;
    logic                out_free;
    logic                take;
    logic                issue;
    logic                idx_last;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign idx_last  = (idx_reg == POS_W'(FRAME_SAMPLES - 1));
    assign mem_raddr = base_reg + AW'(idx_reg);
    assign mem_re    = issue;

    always_comb
    begin
        state_next     = state_reg;
        take           = 1'b0;
        issue          = 1'b0;
        run_done       = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            BK_IDLE:
            begin
                take = q_valid && (q_job.run || out_free);
                if (take && !q_job.run)
                begin
                    out_valid_next = 1'b1;
                end
                if (take && q_job.run)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                // read data lands while the output register is free
                issue = !rd_pend_reg && out_free;
                if (rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    run_done       = idx_last;
                    if (idx_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        rd_pend_next = issue;
        q_ready      = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg  <= q_job;
            base_reg <= q_base;
            idx_reg  <= '0;
        end
        else if (rd_pend_reg)
        begin
            idx_reg <= idx_reg + POS_W'(1);
        end
        if (take && !q_job.run)
        begin
            sample_reg <= '0;
            last_reg   <= 1'b1;
            ok_reg     <= q_job.ok;
            frames_reg <= q_job.frames;
            ufl_reg    <= q_job.underflow;
            ovf_reg    <= q_job.overflow;
        end
        else if (rd_pend_reg)
        begin
            sample_reg <= mem_rdata;
            last_reg   <= idx_last;
            ok_reg     <= 1'b1;
            frames_reg <= job_reg.frames;
            ufl_reg    <= job_reg.underflow;
            ovf_reg    <= job_reg.overflow;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.sample_out      = sample_reg;
    assign out_ch.last            = last_reg;
    assign out_ch.ok              = ok_reg;
    assign out_ch.frames_held     = frames_reg;
    assign out_ch.underflow_total = ufl_reg;
    assign out_ch.overflow_total  = ovf_reg;

    `AFRDO_IMPLIES(a_pend_out_free, rd_pend_reg, !out_valid_reg)
    `AFRDO_IMPLIES(a_pend_in_run, rd_pend_reg, state_reg == BK_RUN)
    `AFRDO_IMPLIES_NEXT(a_pend_loads, rd_pend_reg, out_valid_reg)
    `AFRDO_ASSERT(a_no_take_in_run, !(state_reg == BK_RUN && q_ready))

endmodule

FILE: src/audio_frame_ring_drop_oldest.sv
// top level of the overwriting audio frame ring
`timescale 1ns / 1ps
// in_ch carries requests (opcode, sample_in); out_ch carries results with
// the popped sample, a last mark, ok, frames held and both wrapping totals.
// push, clear, unknown opcodes and a pop on an empty ring give one result
// each, passing through the job queue and then the output register; a
// request is taken every cycle while the job queue has room and no pop is
// being read out. a pop on a non-empty ring gives FRAME_SAMPLES results;
// each sample takes a ram read issue, then an output register load, and
// the next read is issued only once the output register is free. no
// request is taken from a pop until its last sample is in the output
// register, so pushes never overwrite a frame that is being read out.
// reset empties the ring and zeroes both totals; ram contents are not
// cleared since a frame is only read after all its samples are written.
// when the receiver stalls the output register holds, the two-entry job
// queue fills and in_ch.ready drops.
module audio_frame_ring_drop_oldest import afrdo_pkg::*; #(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    afrdo_in_if.sink    in_ch,
    afrdo_out_if.source out_ch
);

    localparam int STORE_WORDS = CAPACITY * FRAME_SAMPLES;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int QW          = JOB_W + AW;

    logic                fq_valid;
    logic                fq_ready;
    job_t                fq_job;
    logic [AW-1:0]       fq_base;
    logic                bq_valid;
    logic                bq_ready;
    job_t                bq_job;
    logic [AW-1:0]       bq_base;
    logic [QW-1:0]       bq_data;
    logic                run_done;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [SAMPLE_W-1:0] mem_rdata;

    afrdo_front #(
        .CAPACITY      (CAPACITY),
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .run_done  (run_done),
        .q_ready   (fq_ready),
        .q_valid   (fq_valid),
        .q_job     (fq_job),
        .q_base    (fq_base),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    afrdo_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  ({fq_job, fq_base}),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_data)
    );

    assign bq_job  = bq_data[QW-1:AW];
    assign bq_base = bq_data[AW-1:0];

    afrdo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    afrdo_back #(
        .CAPACITY      (CAPACITY),
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (bq_valid),
        .q_ready   (bq_ready),
        .q_job     (bq_job),
        .q_base    (bq_base),
        .run_done  (run_done),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_ch    (out_ch)
    );

endmodule
